>>> rtl/aeg_pkg.sv
package aeg_pkg;

    // Parameter defaults
    localparam int MAX_LEVEL_DEF = 256;
    localparam int AMP_W_DEF     = $clog2(MAX_LEVEL_DEF + 1);

    // Fixed field widths
    localparam int PORT_W     = 16;
    localparam int PIN_W      = 4;
    localparam int LEN_W      = 16;
    localparam int SUS_W      = 9;
    localparam int PHASE_W    = 3;
    localparam int CNT_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_INDEX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_LEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_LEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd4;

    // Configuration reset values
    localparam logic [PIN_W-1:0] PIN_INDEX_RST     = 4'd0;
    localparam logic [LEN_W-1:0] ATTACK_LEN_RST    = 16'd160;
    localparam logic [LEN_W-1:0] DECAY_LEN_RST     = 16'd1600;
    localparam logic [LEN_W-1:0] RELEASE_LEN_RST   = 16'd3200;
    localparam logic [SUS_W-1:0] SUSTAIN_LEVEL_RST = 9'd103;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_IDLE_STEP,
        CMD_SUS_STEP,
        CMD_RAMP_LOAD,
        CMD_RAMP_APPLY,
        CMD_RST_LOAD,
        CMD_RST_APPLY,
        CMD_PUBLISH
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RAMP_LOAD,
        ST_RAMP_DIV,
        ST_RAMP_APPLY,
        ST_RST_LOAD,
        ST_RST_DIV,
        ST_RST_APPLY,
        ST_PUBLISH
    } t_state;

    typedef struct packed {
        logic [PIN_W-1:0] pin_index;
        logic [LEN_W-1:0] attack_len;
        logic [LEN_W-1:0] decay_len;
        logic [LEN_W-1:0] release_len;
        logic [SUS_W-1:0] sustain_level;
    } t_cfg;

    typedef struct packed {
        t_phase phase;
        logic   key_edge;
        logic   div_busy;
        logic   out_free;
    } t_status;

endpackage

>>> rtl/aeg_ifs.sv
interface aeg_cfg_if import aeg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface aeg_in_if import aeg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PORT_W-1:0] port_word;

    modport source (output valid, port_word, input ready);
    modport sink   (input valid, port_word, output ready);
endinterface

interface aeg_out_if import aeg_pkg::*; #(
    parameter int AMP_W = AMP_W_DEF
) ();
    logic               valid;
    logic               ready;
    logic [AMP_W-1:0]   amplitude;
    logic [PHASE_W-1:0] phase_out;

    modport source (output valid, amplitude, phase_out, input ready);
    modport sink   (input valid, amplitude, phase_out, output ready);
endinterface

>>> rtl/adsr_envelope_generator_core.sv
// Linear ADSR envelope generator, advanced by one sample tick per input transfer.
// i_in carries the sampled 16-bit port word; the key on bit pin_index is active
// low and a press counts on its rising edge. o_out returns one transfer per
// tick: the amplitude after that tick and the phase (idle, attack, decay,
// sustain, release). i_cfg writes the five setup registers by index; it is
// always ready and is meant to be used only while the block is idle.
// A ramp tick runs one multiply and one serial divide through a shared
// restoring divider of CNT_W + amplitude-width steps. A press that restarts
// attack from decay or release runs a second divide; a press from sustain runs
// only the restart divide.
// One tick is in flight at a time; the next is taken once the last is published.
// Reset (synchronous, active low) restores the register defaults, clears the
// envelope to idle at level zero and drops any pending result.
// A result waits in the output register while the receiver stalls; the next
// tick is still taken and processed, and it holds at its end until the output
// register is free.
module adsr_envelope_generator_core import aeg_pkg::*; #(
    parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aeg_cfg_if.sink     i_cfg,
    aeg_in_if.sink      i_in,
    aeg_out_if.source   o_out
);

    localparam int AMP_W = $clog2(MAX_LEVEL + 1);

    t_cfg    r_cfg, n_cfg;
    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    // Setup registers: take every write, ignore indexes past the list
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PIN_INDEX:     n_cfg.pin_index     = i_cfg.data[PIN_W-1:0];
                CFG_ATTACK_LEN:    n_cfg.attack_len    = i_cfg.data[LEN_W-1:0];
                CFG_DECAY_LEN:     n_cfg.decay_len     = i_cfg.data[LEN_W-1:0];
                CFG_RELEASE_LEN:   n_cfg.release_len   = i_cfg.data[LEN_W-1:0];
                CFG_SUSTAIN_LEVEL: n_cfg.sustain_level = i_cfg.data[SUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pin_index     <= PIN_INDEX_RST;
            r_cfg.attack_len    <= ATTACK_LEN_RST;
            r_cfg.decay_len     <= DECAY_LEN_RST;
            r_cfg.release_len   <= RELEASE_LEN_RST;
            r_cfg.sustain_level <= SUSTAIN_LEVEL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Sequencer: accept, evaluate, optional ramp divide, optional restart divide, publish
    aeg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // Envelope state, shared multiplier and divider, output register
    aeg_dp #(
        .MAX_LEVEL (MAX_LEVEL),
        .AMP_W     (AMP_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (r_cfg),
        .i_port_word (i_in.port_word),
        .i_out_ready (o_out.ready),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .o_amplitude (o_out.amplitude),
        .o_phase_out (o_out.phase_out)
    );

endmodule

>>> rtl/aeg_div.sv
module aeg_div import aeg_pkg::*; #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_count, n_count;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [NUM_W-1:0]  r_quo, n_quo;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [DEN_W:0]    shifted;
    logic              fits;

    // One restoring step a cycle, quotient bit shifts in from the right
    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign fits    = shifted >= {1'b0, r_den};

    always_comb begin
        n_busy  = r_busy;
        n_count = r_count;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        if (i_start) begin
            n_busy  = 1'b1;
            n_count = STEP_W'(NUM_W);
            n_rem   = '0;
            n_quo   = i_num;
            n_den   = i_den;
        end else if (r_busy) begin
            n_rem   = fits ? DEN_W'(shifted - {1'b0, r_den}) : shifted[DEN_W-1:0];
            n_quo   = {r_quo[NUM_W-2:0], fits};
            n_count = r_count - 1'b1;
            if (r_count == STEP_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

>>> rtl/aeg_dp.sv
module aeg_dp import aeg_pkg::*; #(
    parameter int MAX_LEVEL = MAX_LEVEL_DEF,
    parameter int AMP_W     = $clog2(MAX_LEVEL + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_cfg               i_cfg,
    input  logic [PORT_W-1:0]  i_port_word,
    input  logic               i_out_ready,
    output t_status            o_status,
    output logic               o_out_valid,
    output logic [AMP_W-1:0]   o_amplitude,
    output logic [PHASE_W-1:0] o_phase_out
);

    localparam int CMP_W = (AMP_W > SUS_W) ? AMP_W : SUS_W;
    localparam int NUM_W = CNT_W + AMP_W;
    localparam logic [AMP_W-1:0] LVL_MAX = AMP_W'(MAX_LEVEL);

    function automatic logic [LEN_W-1:0] len_fix(input logic [LEN_W-1:0] v);
        return (v == '0) ? LEN_W'(1) : v;
    endfunction

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_tick, n_tick;
    logic [AMP_W-1:0]   r_level, n_level;
    logic               r_last, n_last;
    logic               r_pressed, n_pressed;
    logic               r_edge, n_edge;
    logic               r_out_valid, n_out_valid;
    logic [AMP_W-1:0]   r_amp, n_amp;
    logic [PHASE_W-1:0] r_ph_out, n_ph_out;

    logic               pressed_now;
    logic [AMP_W-1:0]   sus;
    logic [AMP_W-1:0]   scale;
    logic [LEN_W-1:0]   ramp_den;
    logic [CNT_W-1:0]   tick_inc;
    logic [CNT_W-1:0]   mul_a;
    logic [AMP_W-1:0]   mul_b;
    logic [NUM_W-1:0]   product;
    logic               div_start;
    logic [LEN_W-1:0]   div_den;
    logic               div_busy;
    logic [NUM_W-1:0]   quo;
    logic               reached;
    logic [AMP_W-1:0]   q_low;

    assign pressed_now = ~i_port_word[i_cfg.pin_index];

    // Sustain above full scale holds at full scale
    assign sus = (CMP_W'(i_cfg.sustain_level) > CMP_W'(MAX_LEVEL)) ? LVL_MAX
               : AMP_W'(i_cfg.sustain_level);

    always_comb begin
        case (r_phase)
            PH_DECAY: begin
                scale    = LVL_MAX - sus;
                ramp_den = len_fix(i_cfg.decay_len);
            end
            PH_RELEASE: begin
                scale    = sus;
                ramp_den = len_fix(i_cfg.release_len);
            end
            default: begin
                scale    = LVL_MAX;
                ramp_den = len_fix(i_cfg.attack_len);
            end
        endcase
    end

    assign tick_inc  = r_tick + 1'b1;
    assign mul_a     = (i_cmd == CMD_RST_LOAD) ? CNT_W'(len_fix(i_cfg.attack_len)) : tick_inc;
    assign mul_b     = (i_cmd == CMD_RST_LOAD) ? r_level : scale;
    assign product   = NUM_W'(mul_a) * NUM_W'(mul_b);
    assign div_start = (i_cmd == CMD_RAMP_LOAD) || (i_cmd == CMD_RST_LOAD);
    assign div_den   = (i_cmd == CMD_RST_LOAD) ? LEN_W'(MAX_LEVEL) : ramp_den;

    aeg_div #(
        .NUM_W (NUM_W),
        .DEN_W (LEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (product),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (quo)
    );

    assign reached = quo >= NUM_W'(scale);
    assign q_low   = quo[AMP_W-1:0];

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_level     = r_level;
        n_last      = r_last;
        n_pressed   = r_pressed;
        n_edge      = r_edge;
        n_out_valid = r_out_valid && !i_out_ready;
        n_amp       = r_amp;
        n_ph_out    = r_ph_out;
        case (i_cmd)
            CMD_CAPTURE: begin
                n_pressed = pressed_now;
                n_edge    = pressed_now && !r_last;
                n_last    = pressed_now;
            end
            CMD_IDLE_STEP: begin
                if (r_edge) begin
                    n_phase = PH_ATTACK;
                    n_tick  = '0;
                end
            end
            CMD_SUS_STEP: begin
                if (r_edge) begin
                    n_level = sus;
                end else if (!r_pressed) begin
                    n_phase = PH_RELEASE;
                    n_tick  = '0;
                end
            end
            CMD_RAMP_LOAD: begin
                n_tick = tick_inc;
            end
            CMD_RAMP_APPLY: begin
                case (r_phase)
                    PH_DECAY: begin
                        if (reached) begin
                            n_level = sus;
                            n_phase = PH_SUSTAIN;
                        end else begin
                            n_level = LVL_MAX - q_low;
                        end
                    end
                    PH_RELEASE: begin
                        if (reached) begin
                            n_level = '0;
                            n_phase = PH_IDLE;
                        end else begin
                            n_level = sus - q_low;
                        end
                    end
                    default: begin
                        if (reached) begin
                            n_level = LVL_MAX;
                            n_phase = PH_DECAY;
                            n_tick  = '0;
                        end else begin
                            n_level = q_low;
                        end
                    end
                endcase
            end
            CMD_RST_APPLY: begin
                n_tick  = quo[CNT_W-1:0];
                n_phase = PH_ATTACK;
            end
            CMD_PUBLISH: begin
                n_out_valid = 1'b1;
                n_amp       = r_level;
                n_ph_out    = r_phase;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_level     <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_level     <= n_level;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pressed <= n_pressed;
        r_edge    <= n_edge;
        r_amp     <= n_amp;
        r_ph_out  <= n_ph_out;
    end

    assign o_status.phase    = r_phase;
    assign o_status.key_edge = r_edge;
    assign o_status.div_busy = div_busy;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_amplitude = r_amp;
    assign o_phase_out = r_ph_out;

endmodule

>>> rtl/aeg_ctrl.sv
module aeg_ctrl import aeg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_restart, n_restart;

    // Next state
    always_comb begin
        n_state   = r_state;
        n_restart = r_restart;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_restart = i_status.key_edge &&
                            (i_status.phase == PH_DECAY || i_status.phase == PH_RELEASE);
                case (i_status.phase)
                    PH_IDLE:    n_state = ST_PUBLISH;
                    PH_SUSTAIN: n_state = i_status.key_edge ? ST_RST_LOAD : ST_PUBLISH;
                    default:    n_state = ST_RAMP_LOAD;
                endcase
            end
            ST_RAMP_LOAD: n_state = ST_RAMP_DIV;
            ST_RAMP_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = ST_RAMP_APPLY;
                end
            end
            ST_RAMP_APPLY: n_state = r_restart ? ST_RST_LOAD : ST_PUBLISH;
            ST_RST_LOAD:   n_state = ST_RST_DIV;
            ST_RST_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = ST_RST_APPLY;
                end
            end
            ST_RST_APPLY: n_state = ST_PUBLISH;
            ST_PUBLISH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = CMD_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd = CMD_CAPTURE;
                end
            end
            ST_EVAL: begin
                case (i_status.phase)
                    PH_IDLE:    o_cmd = CMD_IDLE_STEP;
                    PH_SUSTAIN: o_cmd = CMD_SUS_STEP;
                    default:    o_cmd = CMD_NONE;
                endcase
            end
            ST_RAMP_LOAD:  o_cmd = CMD_RAMP_LOAD;
            ST_RAMP_APPLY: o_cmd = CMD_RAMP_APPLY;
            ST_RST_LOAD:   o_cmd = CMD_RST_LOAD;
            ST_RST_APPLY:  o_cmd = CMD_RST_APPLY;
            ST_PUBLISH: begin
                if (i_status.out_free) begin
                    o_cmd = CMD_PUBLISH;
                end
            end
            default: o_cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_restart <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_restart <= n_restart;
        end
    end

endmodule
